@@ rtl/core/ipv4_inbound_policy_classifier_unit_assert.svh @@
// ----------------------------------------------------------------------------
// IPv4 inbound policy classifier assertion macros
// Shared property forms used by the checker of the classifier block.
// ----------------------------------------------------------------------------
`ifndef IPV4_INBOUND_POLICY_CLASSIFIER_UNIT_ASSERT_SVH
`define IPV4_INBOUND_POLICY_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPIC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ipic_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv4 inbound policy classifier package
// Sizes, codes, item types and controller interface types of the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ipic_pkg;

  // Table and SA sizing.
  localparam int POLICY_SLOTS = 64;
  localparam int SA_COUNT     = 1024;
  localparam int SLOT_W       = (POLICY_SLOTS > 1) ? $clog2(POLICY_SLOTS) : 1;
  localparam int FIELD_SLOT_W = 6;
  localparam int FIELD_SA_W   = 10;

  // Item commands.
  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;

  // Protocol classes.
  localparam logic [1:0] PROTO_ESP = 2'd0;
  localparam logic [1:0] PROTO_AH  = 2'd1;

  // Verdict codes.
  localparam logic [2:0] V_ESP     = 3'd0;
  localparam logic [2:0] V_AH      = 3'd1;
  localparam logic [2:0] V_BYPASS  = 3'd2;
  localparam logic [2:0] V_DISCARD = 3'd3;
  localparam logic [2:0] V_NOMATCH = 3'd4;
  localparam logic [2:0] V_PASS    = 3'd5;

  // Policy entry kinds.
  typedef enum logic [1:0] {
    KIND_PROTECT = 2'd0,
    KIND_BYPASS  = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_LAST = 2'd2,
    S_DONE = 2'd3
  } state_t;

  // Input item.
  typedef struct packed {
    logic                    cmd;
    logic [FIELD_SLOT_W-1:0] entry_slot;
    logic [1:0]              entry_kind;
    logic                    entry_is_tunnel;
    logic [FIELD_SA_W-1:0]   entry_sa;
    logic [31:0]             src_addr;
    logic [31:0]             dst_addr;
    logic [31:0]             src_addr_end;
    logic [31:0]             dst_addr_end;
    logic [31:0]             spi_value;
    logic [1:0]              proto_class;
    logic                    header_fits;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [2:0]              verdict;
    logic                    hit_found;
    logic [FIELD_SLOT_W-1:0] hit_slot;
    logic [FIELD_SA_W-1:0]   hit_sa;
  } out_item_t;

  // One stored policy entry.
  typedef struct packed {
    kind_t                 kind;
    logic                  tunnel;
    logic [FIELD_SA_W-1:0] sa;
    logic [31:0]           src_low;
    logic [31:0]           src_high;
    logic [31:0]           dst_low;
    logic [31:0]           dst_high;
    logic [31:0]           spi;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;
    logic wr_en;
    logic scan;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_write;
    logic is_pass;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/ipic_table.sv @@
// ----------------------------------------------------------------------------
// IPv4 inbound policy classifier policy table
// Policy memory with one write port, one registered read port and per-slot valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ipic_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [ipic_pkg::SLOT_W-1:0] wr_slot,
  input  wire ipic_pkg::entry_t           wr_entry,
  input  wire logic                       rd_en,
  input  wire logic [ipic_pkg::SLOT_W-1:0] rd_slot,
  output ipic_pkg::entry_t                rd_entry
);

  ipic_pkg::entry_t                     policy_mem_r [ipic_pkg::POLICY_SLOTS];
  logic [ipic_pkg::POLICY_SLOTS-1:0]    slot_valid_r;
  ipic_pkg::entry_t                     rd_data_r;
  logic                                 rd_valid_r;

  // Entry storage and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      policy_mem_r[wr_slot] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= policy_mem_r[rd_slot];
    end
  end

  // Valid bits: reset marks every slot empty at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      rd_valid_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_valid_r[wr_slot] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= slot_valid_r[rd_slot];
      end
    end
  end

  // A slot never written reads as empty.
  always_comb begin
    rd_entry = rd_data_r;
    if (!rd_valid_r) begin
      rd_entry.kind = ipic_pkg::KIND_EMPTY;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ipic_datapath.sv @@
// ----------------------------------------------------------------------------
// IPv4 inbound policy classifier datapath
// Packet capture, slot scan counter, match logic, hit tracking, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipic_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ipic_pkg::in_item_t   in_data,
  input  wire ipic_pkg::ctrl_cmd_t  cmd,
  output ipic_pkg::dp_status_t      status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ipic_pkg::out_item_t       out_data
);

  // Captured packet fields.
  logic [31:0]                    pkt_src_r;
  logic [31:0]                    pkt_dst_r;
  logic [31:0]                    pkt_spi_r;
  logic [1:0]                     pkt_proto_r;
  logic                           pkt_fits_r;
  logic                           pkt_pass_r;

  // Scan address and read pipeline.
  logic [ipic_pkg::SLOT_W-1:0]    addr_r;
  logic [ipic_pkg::SLOT_W-1:0]    rd_slot_r;
  logic                           rd_pend_r;

  // First hit of each kind.
  logic                           gp_r, gp_nxt;
  logic                           gb_r, gb_nxt;
  logic                           gd_r, gd_nxt;
  logic [ipic_pkg::SLOT_W-1:0]    hp_r, hp_nxt;
  logic [ipic_pkg::SLOT_W-1:0]    hb_r, hb_nxt;
  logic [ipic_pkg::SLOT_W-1:0]    hd_r, hd_nxt;
  logic [ipic_pkg::FIELD_SA_W-1:0] hp_sa_r, hp_sa_nxt;

  // Result register.
  logic                           out_valid_r;
  ipic_pkg::out_item_t            out_data_r;
  ipic_pkg::out_item_t            result;

  ipic_pkg::entry_t               wr_entry;
  ipic_pkg::entry_t               rd_entry;
  logic                           wr_ok;
  logic                           ranges_hold;
  logic                           protect_hit;
  logic                           bypass_hit;
  logic                           discard_hit;

  // Writes outside the table or the SA space are dropped.
  assign wr_ok = (32'(in_data.entry_slot) < ipic_pkg::POLICY_SLOTS) &&
                 (32'(in_data.entry_sa) < ipic_pkg::SA_COUNT);

  always_comb begin
    wr_entry.kind     = ipic_pkg::kind_t'(in_data.entry_kind);
    wr_entry.tunnel   = in_data.entry_is_tunnel;
    wr_entry.sa       = in_data.entry_sa;
    wr_entry.src_low  = in_data.src_addr;
    wr_entry.src_high = in_data.src_addr_end;
    wr_entry.dst_low  = in_data.dst_addr;
    wr_entry.dst_high = in_data.dst_addr_end;
    wr_entry.spi      = in_data.spi_value;
  end

  ipic_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd.wr_en && wr_ok),
    .wr_slot  (ipic_pkg::SLOT_W'(in_data.entry_slot)),
    .wr_entry (wr_entry),
    .rd_en    (cmd.scan),
    .rd_slot  (addr_r),
    .rd_entry (rd_entry)
  );

  // Status toward the controller.
  always_comb begin
    status.is_write  = (in_data.cmd == ipic_pkg::CMD_WRITE);
    status.is_pass   = (in_data.proto_class != ipic_pkg::PROTO_ESP) &&
                       (in_data.proto_class != ipic_pkg::PROTO_AH);
    status.scan_last = (addr_r == ipic_pkg::SLOT_W'(ipic_pkg::POLICY_SLOTS - 1));
    status.out_free  = !out_valid_r || out_ready;
  end

  // Packet capture; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pkt_src_r   <= in_data.src_addr;
      pkt_dst_r   <= in_data.dst_addr;
      pkt_spi_r   <= in_data.spi_value;
      pkt_proto_r <= in_data.proto_class;
      pkt_fits_r  <= in_data.header_fits;
      pkt_pass_r  <= status.is_pass;
    end
    if (cmd.scan) begin
      rd_slot_r <= addr_r;
    end
  end

  // Scan address counter and read-pending flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan;
      if (cmd.start) begin
        addr_r <= '0;
      end else if (cmd.scan) begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  // Match logic on the slot read out last cycle.
  always_comb begin
    ranges_hold = (pkt_dst_r >= rd_entry.dst_low) && (pkt_dst_r <= rd_entry.dst_high) &&
                  (pkt_src_r >= rd_entry.src_low) && (pkt_src_r <= rd_entry.src_high);
    protect_hit = (rd_entry.kind == ipic_pkg::KIND_PROTECT) && (rd_entry.spi == pkt_spi_r) &&
                  (rd_entry.tunnel ? ((pkt_dst_r == rd_entry.dst_low) &&
                                      (pkt_src_r == rd_entry.src_low))
                                   : ranges_hold);
    bypass_hit  = (rd_entry.kind == ipic_pkg::KIND_BYPASS) && ranges_hold;
    discard_hit = (rd_entry.kind == ipic_pkg::KIND_DISCARD) && ranges_hold;
  end

  // Keep the first hit of each kind.
  always_comb begin
    gp_nxt    = gp_r;
    gb_nxt    = gb_r;
    gd_nxt    = gd_r;
    hp_nxt    = hp_r;
    hb_nxt    = hb_r;
    hd_nxt    = hd_r;
    hp_sa_nxt = hp_sa_r;
    if (cmd.start) begin
      gp_nxt = 1'b0;
      gb_nxt = 1'b0;
      gd_nxt = 1'b0;
    end else if (rd_pend_r) begin
      if (!gp_r && protect_hit) begin
        gp_nxt    = 1'b1;
        hp_nxt    = rd_slot_r;
        hp_sa_nxt = rd_entry.sa;
      end
      if (!gb_r && bypass_hit) begin
        gb_nxt = 1'b1;
        hb_nxt = rd_slot_r;
      end
      if (!gd_r && discard_hit) begin
        gd_nxt = 1'b1;
        hd_nxt = rd_slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r <= 1'b0;
      gb_r <= 1'b0;
      gd_r <= 1'b0;
    end else begin
      gp_r <= gp_nxt;
      gb_r <= gb_nxt;
      gd_r <= gd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hp_r    <= hp_nxt;
    hb_r    <= hb_nxt;
    hd_r    <= hd_nxt;
    hp_sa_r <= hp_sa_nxt;
  end

  // Verdict selection: pass for other protocols, then protect (if the header fits), bypass, discard, else no match.
  always_comb begin
    result.verdict   = ipic_pkg::V_NOMATCH;
    result.hit_found = 1'b0;
    result.hit_slot  = '0;
    result.hit_sa    = '0;
    if (pkt_pass_r) begin
      result.verdict = ipic_pkg::V_PASS;
    end else if (gp_r && pkt_fits_r) begin
      result.verdict   = (pkt_proto_r == ipic_pkg::PROTO_ESP) ? ipic_pkg::V_ESP
                                                               : ipic_pkg::V_AH;
      result.hit_found = 1'b1;
      result.hit_slot  = ipic_pkg::FIELD_SLOT_W'(hp_r);
      result.hit_sa    = hp_sa_r;
    end else if (gb_r) begin
      result.verdict   = ipic_pkg::V_BYPASS;
      result.hit_found = 1'b1;
      result.hit_slot  = ipic_pkg::FIELD_SLOT_W'(hb_r);
    end else if (gd_r) begin
      result.verdict   = ipic_pkg::V_DISCARD;
      result.hit_found = 1'b1;
      result.hit_slot  = ipic_pkg::FIELD_SLOT_W'(hd_r);
    end
  end

  // Output register holds an item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/ipic_ctrl.sv @@
// ----------------------------------------------------------------------------
// IPv4 inbound policy classifier controller
// Sequences item acceptance, the table scan and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ipic_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ipic_pkg::dp_status_t status,
  output ipic_pkg::ctrl_cmd_t       cmd
);

  ipic_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipic_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipic_pkg::S_IDLE: begin
        if (in_valid && !status.is_write) begin
          state_nxt = status.is_pass ? ipic_pkg::S_DONE : ipic_pkg::S_SCAN;
        end
      end
      ipic_pkg::S_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ipic_pkg::S_LAST;
        end
      end
      ipic_pkg::S_LAST: begin
        state_nxt = ipic_pkg::S_DONE;
      end
      ipic_pkg::S_DONE: begin
        if (status.out_free) begin
          state_nxt = ipic_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ipic_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.wr_en    = 1'b0;
    cmd.scan     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ipic_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.wr_en = in_valid && status.is_write;
        cmd.start = in_valid && !status.is_write;
      end
      ipic_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      ipic_pkg::S_LAST: begin
        cmd.scan = 1'b0;
      end
      ipic_pkg::S_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/ipv4_inbound_policy_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// IPv4 inbound policy classifier unit
// Inbound security policy lookup over a table of protect, bypass and discard
// entries, with a controller and a datapath.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the in_ channel (valid/ready). A write item loads one policy
// slot while the block is idle; it yields no result. A classify item yields
// one result item on the out_ channel (valid/ready).
// A classify item for ESP or AH scans every policy slot, one slot per cycle
// through the table's registered read port, then loads its result into the
// output register, and the next item can be taken in the same cycle that the
// result becomes valid. Other protocols skip the scan and go straight to the
// result load.
// Reset clears the per-slot valid bits at once, so every slot reads empty;
// there is no clearing pass. The result sits in an output register; while
// the receiver stalls, the block still takes write items and the next
// classify item, and a finished classify waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_inbound_policy_classifier_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ipic_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ipic_pkg::out_item_t      out_data
);

  ipic_pkg::ctrl_cmd_t  cmd;
  ipic_pkg::dp_status_t status;

  // Controller.
  ipic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath with the policy table.
  ipic_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/ipic_checker.sv @@
// ----------------------------------------------------------------------------
// IPv4 inbound policy classifier checker
// Port-level properties of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_inbound_policy_classifier_unit_assert.svh"

module ipic_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire ipic_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire ipic_pkg::out_item_t out_data
);

  // A stalled result keeps its value.
  `IPIC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // A classify item keeps the block busy in the following cycle.
  `IPIC_ASSERT_NEXT(a_busy_after_classify, clk, rst_n, in_valid && in_ready && (in_data.cmd == ipic_pkg::CMD_CLASSIFY), !in_ready, "input taken during classify")

  // No deciding entry means a zero slot and SA.
  `IPIC_ASSERT_IMPLY(a_no_hit_zero, clk, rst_n, out_valid && !out_data.hit_found, (out_data.hit_slot == '0) && (out_data.hit_sa == '0), "slot or SA without hit")

  // Only decrypt verdicts carry an SA.
  `IPIC_ASSERT_IMPLY(a_sa_only_protect, clk, rst_n, out_valid && (out_data.verdict != ipic_pkg::V_ESP) && (out_data.verdict != ipic_pkg::V_AH), out_data.hit_sa == '0, "SA on non-decrypt verdict")

  // Hit flag agrees with the verdict class.
  `IPIC_ASSERT_IMPLY(a_hit_verdict, clk, rst_n, out_valid, out_data.hit_found == ((out_data.verdict != ipic_pkg::V_NOMATCH) && (out_data.verdict != ipic_pkg::V_PASS)), "hit flag and verdict disagree")

endmodule

bind ipv4_inbound_policy_classifier_unit ipic_checker u_ipic_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
